[rtl/core/scheduled_led_soft_ramp_dimmer_core_assert.svh]
// assertion macros shared by the checker
`ifndef SCHEDULED_LED_SOFT_RAMP_DIMMER_CORE_ASSERT_SVH
`define SCHEDULED_LED_SOFT_RAMP_DIMMER_CORE_ASSERT_SVH

// checked on every clock edge out of reset
`define SLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked on every clock edge, reset included
`define SLD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/core/sld_pkg.sv]
`default_nettype none

package sld_pkg;

  localparam int ChanCount   = 3;
  localparam int OutChannels = 3;
  localparam int MaskW       = 3;
  localparam int ChanIdxW    = (ChanCount > 1) ? $clog2(ChanCount) : 1;

  localparam int DutyW    = 10;
  localparam int PeriodW  = 11;
  localparam int SecondW  = 17;
  localparam int HourW    = 5;
  localparam int MinuteW  = 6;
  localparam int SecW     = 6;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 17;

  // divider: dividend is power plus offset, one quotient bit per step
  localparam int DivW     = DutyW + 1;
  localparam int DivSteps = DivW;
  localparam int DivCntW  = $clog2(DivSteps);

  localparam logic [DivW-1:0]    PeriodOffset  = 11'd430;
  localparam logic [PeriodW-1:0] PeriodBias    = 11'd10;
  localparam logic [PeriodW-1:0] StartPeriod   = 11'd9;
  localparam logic [SecondW-1:0] SecsPerHour   = 17'd3600;
  localparam logic [SecondW-1:0] SecsPerMinute = 17'd60;
  localparam logic [DutyW-1:0]   DivisorReset  = 10'd10;
  localparam logic [DutyW-1:0]   StepReset     = 10'd10;

  localparam logic FuncTime   = 1'b0;
  localparam logic FuncExpiry = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET_CH1   = 3'd0,
    CFG_TARGET_CH2   = 3'd1,
    CFG_TARGET_CH3   = 3'd2,
    CFG_WIN_START    = 3'd3,
    CFG_WIN_STOP     = 3'd4,
    CFG_SMOOTH       = 3'd5,
    CFG_DIVISOR      = 3'd6,
    CFG_RAMP_STEP    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic               func;
    logic [HourW-1:0]   time_hour;
    logic [MinuteW-1:0] time_minute;
    logic [SecW-1:0]    time_second;
    logic [MaskW-1:0]   expired_mask;
  } sld_in_t;

  typedef struct packed {
    logic [DutyW-1:0]   duty_ch1;
    logic [DutyW-1:0]   duty_ch2;
    logic [DutyW-1:0]   duty_ch3;
    logic [PeriodW-1:0] period_ch1;
    logic [PeriodW-1:0] period_ch2;
    logic [PeriodW-1:0] period_ch3;
    logic               ramp_timer_on;
    logic               pwm_on;
    logic               window_active;
  } sld_out_t;

  typedef struct packed {
    logic load;
    logic apply;
    logic div_start;
    logic div_step;
    logic div_last;
    logic emit;
  } sld_cmd_t;

  typedef struct packed {
    logic pend_any;
    logic out_free;
  } sld_stat_t;

endpackage

`default_nettype wire

[rtl/core/sld_in_if.sv]
`default_nettype none

interface sld_in_if import sld_pkg::*; ();
  logic    valid;
  logic    ready;
  sld_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/sld_out_if.sv]
`default_nettype none

interface sld_out_if import sld_pkg::*; ();
  logic     valid;
  logic     ready;
  sld_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/sld_ctrl.sv]
`default_nettype none

module sld_ctrl import sld_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sld_stat_t stat_i,
  output sld_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_APPLY = 5'b00010,
    ST_SEL   = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [DivCntW-1:0]   cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_SEL;
      end
      // one period recomputation per pending channel
      ST_SEL: begin
        if (stat_i.pend_any) begin
          cmd_o.div_start = 1'b1;
          cnt_d           = '0;
          state_d         = ST_DIV;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          cmd_o.div_last = 1'b1;
          state_d        = ST_SEL;
        end else begin
          cnt_d = cnt_q + DivCntW'(1);
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/sld_datapath.sv]
`default_nettype none

module sld_datapath import sld_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  sld_in_t             in_data_i,
  input  sld_cmd_t            cmd_i,
  output sld_stat_t           stat_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output sld_out_t            out_data_o
);

  // configuration
  logic [DutyW-1:0]   tgt_q [OutChannels];
  logic [DutyW-1:0]   tgt_d [OutChannels];
  logic [SecondW-1:0] win_start_q, win_start_d;
  logic [SecondW-1:0] win_stop_q, win_stop_d;
  logic               smooth_q, smooth_d;
  logic [DutyW-1:0]   divisor_q, divisor_d;
  logic [DutyW-1:0]   step_q, step_d;

  // channel state
  logic               powered_q, powered_d;
  logic [DutyW-1:0]   cur_q [ChanCount];
  logic [DutyW-1:0]   cur_d [ChanCount];
  logic [DutyW-1:0]   dst_q [ChanCount];
  logic [DutyW-1:0]   dst_d [ChanCount];
  logic [PeriodW-1:0] per_q [ChanCount];
  logic [PeriodW-1:0] per_d [ChanCount];
  logic [DutyW-1:0]   app_q [ChanCount];
  logic [DutyW-1:0]   app_d [ChanCount];
  logic [ChanCount-1:0] done_q, done_d;
  logic [ChanCount-1:0] pend_q, pend_d;
  logic               run_q, run_d;
  logic               oen_q, oen_d;

  // request and divider
  sld_in_t            itm_q, itm_d;
  logic [ChanIdxW-1:0] ch_q, ch_d;
  logic [DutyW-1:0]   rem_q, rem_d;
  logic [DivW-1:0]    quo_q, quo_d;

  // result register
  logic               out_valid_q, out_valid_d;
  sld_out_t           out_data_q, out_data_d;

  logic [SecondW-1:0] now_sec;
  logic               in_window;
  logic [ChanIdxW-1:0] sel_ch;
  logic [DutyW-1:0]   divisor_eff;
  logic [DivW-1:0]    trial, trial_diff;
  logic               trial_ge;
  logic [DutyW-1:0]   step_rem;
  logic [DivW-1:0]    step_quo;
  logic [DutyW-1:0]   tgt_ch [ChanCount];
  logic [DutyW-1:0]   duty_v [OutChannels];
  logic [PeriodW-1:0] per_v [OutChannels];

  assign now_sec = SecondW'(itm_q.time_hour) * SecsPerHour
                 + SecondW'(itm_q.time_minute) * SecsPerMinute
                 + SecondW'(itm_q.time_second);
  assign in_window = (now_sec >= win_start_q) && (now_sec < win_stop_q);

  always_comb begin
    for (int i = 0; i < ChanCount; i++) begin
      tgt_ch[i] = (i < OutChannels) ? tgt_q[i] : '0;
    end
  end

  // lowest pending channel goes first
  always_comb begin
    sel_ch = '0;
    for (int i = ChanCount - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        sel_ch = ChanIdxW'(i);
      end
    end
  end

  assign divisor_eff = (divisor_q == '0) ? DutyW'(1) : divisor_q;
  assign trial       = {rem_q, quo_q[DivW-1]};
  assign trial_ge    = trial >= {1'b0, divisor_eff};
  assign trial_diff  = trial - {1'b0, divisor_eff};
  assign step_rem    = trial_ge ? trial_diff[DutyW-1:0] : trial[DutyW-1:0];
  assign step_quo    = {quo_q[DivW-2:0], trial_ge};

  always_comb begin
    for (int j = 0; j < OutChannels; j++) begin
      if (j < ChanCount) begin
        duty_v[j] = oen_q ? app_q[j] : '0;
        per_v[j]  = per_q[j];
      end else begin
        duty_v[j] = '0;
        per_v[j]  = '0;
      end
    end
  end

  always_comb begin
    logic [DutyW:0] c;
    logic [DutyW:0] d;
    logic [DutyW:0] st;
    logic           all_fin;

    tgt_d       = tgt_q;
    win_start_d = win_start_q;
    win_stop_d  = win_stop_q;
    smooth_d    = smooth_q;
    divisor_d   = divisor_q;
    step_d      = step_q;
    powered_d   = powered_q;
    cur_d       = cur_q;
    dst_d       = dst_q;
    per_d       = per_q;
    app_d       = app_q;
    done_d      = done_q;
    pend_d      = pend_q;
    run_d       = run_q;
    oen_d       = oen_q;
    itm_d       = itm_q;
    ch_d        = ch_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    st          = {1'b0, step_q};
    c           = '0;
    d           = '0;
    all_fin     = 1'b1;

    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TARGET_CH1: tgt_d[0]    = cfg_wdata_i[DutyW-1:0];
        CFG_TARGET_CH2: tgt_d[1]    = cfg_wdata_i[DutyW-1:0];
        CFG_TARGET_CH3: tgt_d[2]    = cfg_wdata_i[DutyW-1:0];
        CFG_WIN_START:  win_start_d = cfg_wdata_i[SecondW-1:0];
        CFG_WIN_STOP:   win_stop_d  = cfg_wdata_i[SecondW-1:0];
        CFG_SMOOTH:     smooth_d    = cfg_wdata_i[0];
        CFG_DIVISOR:    divisor_d   = cfg_wdata_i[DutyW-1:0];
        CFG_RAMP_STEP:  step_d      = cfg_wdata_i[DutyW-1:0];
        default: ;
      endcase
    end

    if (cmd_i.load) begin
      itm_d  = in_data_i;
      pend_d = '0;
    end

    if (cmd_i.apply) begin
      if (itm_q.func == FuncTime) begin
        if (in_window && !powered_q) begin
          powered_d = 1'b1;
          if (smooth_q) begin
            for (int i = 0; i < ChanCount; i++) begin
              cur_d[i]  = '0;
              per_d[i]  = StartPeriod;
              done_d[i] = 1'b0;
              dst_d[i]  = tgt_ch[i];
            end
            run_d = 1'b1;
          end else begin
            run_d = 1'b0;
            for (int i = 0; i < ChanCount; i++) begin
              app_d[i] = tgt_ch[i];
            end
            oen_d = 1'b1;
          end
        end else if (!in_window && powered_q) begin
          powered_d = 1'b0;
          if (smooth_q) begin
            for (int i = 0; i < ChanCount; i++) begin
              // a finished ramp restarts down from the target
              if (cur_q[i] == dst_q[i]) begin
                cur_d[i] = tgt_ch[i];
              end
              dst_d[i]  = '0;
              done_d[i] = 1'b1;
            end
            run_d = 1'b1;
          end else begin
            run_d = 1'b0;
            oen_d = 1'b0;
            for (int i = 0; i < ChanCount; i++) begin
              app_d[i] = '0;
            end
          end
        end
      end else if (run_q) begin
        for (int i = 0; i < ChanCount; i++) begin
          if (i < MaskW && itm_q.expired_mask[i]) begin
            c = {1'b0, cur_q[i]};
            d = {1'b0, dst_q[i]};
            if (powered_q) begin
              if (c < d) begin
                c = ((c + st) > d) ? d : (c + st);
              end
              if (c < d) begin
                pend_d[i] = 1'b1;
              end else begin
                done_d[i] = 1'b1;
              end
            end else begin
              if (c != '0) begin
                c = (c < st) ? '0 : (c - st);
              end
              if (c > d) begin
                pend_d[i] = 1'b1;
              end else begin
                done_d[i] = 1'b0;
              end
            end
            cur_d[i] = c[DutyW-1:0];
            app_d[i] = c[DutyW-1:0];
            oen_d    = 1'b1;
          end
          if (powered_q ? !done_d[i] : done_d[i]) begin
            all_fin = 1'b0;
          end
        end
        if (all_fin) begin
          run_d = 1'b0;
          if (!powered_q) begin
            oen_d = 1'b0;
            for (int i = 0; i < ChanCount; i++) begin
              app_d[i] = '0;
            end
          end
        end
      end
    end

    if (cmd_i.div_start) begin
      ch_d         = sel_ch;
      pend_d[sel_ch] = 1'b0;
      rem_d        = '0;
      quo_d        = {1'b0, cur_q[sel_ch]} + PeriodOffset;
    end

    if (cmd_i.div_step) begin
      rem_d = step_rem;
      quo_d = step_quo;
      if (cmd_i.div_last) begin
        per_d[ch_q] = PeriodW'(step_quo) + PeriodBias;
      end
    end

    if (cmd_i.emit) begin
      out_valid_d              = 1'b1;
      out_data_d.duty_ch1      = duty_v[0];
      out_data_d.duty_ch2      = duty_v[1];
      out_data_d.duty_ch3      = duty_v[2];
      out_data_d.period_ch1    = per_v[0];
      out_data_d.period_ch2    = per_v[1];
      out_data_d.period_ch3    = per_v[2];
      out_data_d.ramp_timer_on = run_q;
      out_data_d.pwm_on        = oen_q;
      out_data_d.window_active = powered_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < OutChannels; i++) begin
        tgt_q[i] <= '0;
      end
      win_start_q <= '0;
      win_stop_q  <= '0;
      smooth_q    <= 1'b0;
      divisor_q   <= DivisorReset;
      step_q      <= StepReset;
      powered_q   <= 1'b0;
      for (int i = 0; i < ChanCount; i++) begin
        cur_q[i] <= '0;
        dst_q[i] <= '0;
        per_q[i] <= StartPeriod;
        app_q[i] <= '0;
      end
      done_q      <= '0;
      pend_q      <= '0;
      run_q       <= 1'b0;
      oen_q       <= 1'b0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tgt_q       <= tgt_d;
      win_start_q <= win_start_d;
      win_stop_q  <= win_stop_d;
      smooth_q    <= smooth_d;
      divisor_q   <= divisor_d;
      step_q      <= step_d;
      powered_q   <= powered_d;
      cur_q       <= cur_d;
      dst_q       <= dst_d;
      per_q       <= per_d;
      app_q       <= app_d;
      done_q      <= done_d;
      pend_q      <= pend_d;
      run_q       <= run_d;
      oen_q       <= oen_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request, divider and result payload
  always_ff @(posedge clk_i) begin
    itm_q      <= itm_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    out_data_q <= out_data_d;
  end

  assign stat_o.pend_any = |pend_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;

endmodule

`default_nettype wire

[rtl/core/scheduled_led_soft_ramp_dimmer_core.sv]
// Three-channel scheduled LED dimmer. Each request is either a time-of-day
// sample (switches the output on inside [start, stop) and off outside it)
// or a ramp timer expiry (steps each flagged channel towards its goal), and
// each request gives exactly one result with the applied duties, the next
// ramp timer periods and the status flags. One request is worked at a time;
// the next one is taken while the previous result still waits in the output
// register. A time sample passes the idle, apply, select and emit states;
// an expiry also runs a select step and the one shared restoring divider,
// one quotient bit per cycle over 11 bits, for each channel whose next
// period is recomputed (at most 3). The controller is ready for the next
// request once the result register is loaded; a result that is not
// taken holds the next request in its last cycle until the output register
// frees up. Registers are written by the user through the plain write port
// while no request is in flight, which the block does not enforce; target
// changes take effect at the next switch on or off.
`default_nettype none

module scheduled_led_soft_ramp_dimmer_core import sld_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  sld_in_if.sink              item_i,
  sld_out_if.source           result_o
);

  sld_cmd_t  cmd;
  sld_stat_t stat;

  sld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sld_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (item_i.data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .out_data_o  (result_o.data)
  );

endmodule

`default_nettype wire

[rtl/core/sld_checker.sv]
`default_nettype none

`include "scheduled_led_soft_ramp_dimmer_core_assert.svh"

module sld_checker import sld_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input sld_out_t out_data_i
);

  // a stalled result keeps its contents
  `SLD_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i), "result changed while stalled")

  // one request in flight at a time
  `SLD_ASSERT(a_one_req, in_valid_i && in_ready_i |=> !in_ready_i, "request taken while busy")

  // pwm off means all duties read zero
  `SLD_ASSERT(a_pwm_off_dark, out_valid_i && !out_data_i.pwm_on |-> out_data_i.duty_ch1 == '0 && out_data_i.duty_ch2 == '0 && out_data_i.duty_ch3 == '0, "duty shown with pwm off")

  // switched off with no ramp running leaves pwm off
  `SLD_ASSERT(a_off_idle, out_valid_i && !out_data_i.window_active && !out_data_i.ramp_timer_on |-> !out_data_i.pwm_on, "pwm left on after switch off")

  `SLD_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_i, "result valid during reset")

endmodule

bind scheduled_led_soft_ramp_dimmer_core sld_checker u_sld_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_data_i  (result_o.data)
);

`default_nettype wire

[sim/testbench.sv]
`default_nettype none

module testbench;
  import sld_pkg::*;

  typedef struct packed {
    logic [DutyW-1:0]   target_ch1;
    logic [DutyW-1:0]   target_ch2;
    logic [DutyW-1:0]   target_ch3;
    logic [SecondW-1:0] win_start;
    logic [SecondW-1:0] win_stop;
    logic               smooth;
    logic [DutyW-1:0]   divisor;
    logic [DutyW-1:0]   step;
  } dimmer_cfg_t;

  typedef enum logic {ROW_SETTINGS, ROW_REQUEST} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    dimmer_cfg_t cfg;
    sld_in_t     req;
    logic        pinned;
    sld_out_t    want;
  } script_row_t;

  localparam sld_out_t Dark = '{10'd0, 10'd0, 10'd0, StartPeriod, StartPeriod, StartPeriod,
                                1'b0, 1'b0, 1'b0};
  localparam sld_out_t Lit = '{10'd1000, 10'd0, 10'd500, StartPeriod, StartPeriod,
                               StartPeriod, 1'b0, 1'b1, 1'b1};

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  sld_in_if  item_if ();
  sld_out_if result_if ();

  // register copy held by the predictor
  int unsigned tgt_duty [3];
  int unsigned win_lo, win_hi, div_n, step_n;
  bit          smooth_on;

  // predicted dimmer state
  bit          powered;
  int unsigned cur_pw [3];
  int unsigned dest_pw [3];
  int unsigned ramp_per [3];
  int unsigned duty_now [3];
  bit          ramp_fin [3];
  bit          timer_on, pwm_en;

  sld_out_t    pending_levels [$];
  script_row_t script [$];
  int unsigned fault_count;
  bit          no_idle;

  scheduled_led_soft_ramp_dimmer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_if),
    .result_o    (result_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int unsigned period_for(int unsigned p);
    int unsigned d;
    d = (div_n == 0) ? 1 : div_n;
    return ((p + PeriodOffset) / d + PeriodBias) & ((1 << PeriodW) - 1);
  endfunction

  function automatic sld_out_t step_dimmer(sld_in_t r);
    int unsigned now, c, d;
    bit          all_fin;
    sld_out_t    o;
    int          i;
    if (r.func == FuncTime) begin
      now = 32'(r.time_hour) * SecsPerHour + 32'(r.time_minute) * SecsPerMinute
            + 32'(r.time_second);
      if (now >= win_lo && now < win_hi) begin
        if (!powered) begin
          powered = 1'b1;
          if (smooth_on) begin
            for (i = 0; i < 3; i++) begin
              cur_pw[i]   = 0;
              ramp_per[i] = StartPeriod;
              ramp_fin[i] = 1'b0;
              dest_pw[i]  = tgt_duty[i];
            end
            timer_on = 1'b1;
          end else begin
            timer_on = 1'b0;
            for (i = 0; i < 3; i++) duty_now[i] = tgt_duty[i];
            pwm_en = 1'b1;
          end
        end
      end else if (powered) begin
        powered = 1'b0;
        if (smooth_on) begin
          // a finished ramp restarts its way down from the stored target
          for (i = 0; i < 3; i++) begin
            if (cur_pw[i] == dest_pw[i]) cur_pw[i] = tgt_duty[i];
            dest_pw[i]  = 0;
            ramp_fin[i] = 1'b1;
          end
          timer_on = 1'b1;
        end else begin
          timer_on = 1'b0;
          pwm_en   = 1'b0;
          for (i = 0; i < 3; i++) duty_now[i] = 0;
        end
      end
    end else if (timer_on) begin
      all_fin = 1'b1;
      for (i = 0; i < 3; i++) begin
        if (r.expired_mask[i]) begin
          c = cur_pw[i];
          d = dest_pw[i];
          if (powered) begin
            if (c < d) c = (c + step_n > d) ? d : c + step_n;
            if (c < d) ramp_per[i] = period_for(c);
            else ramp_fin[i] = 1'b1;
          end else begin
            if (c > 0) c = (c < step_n) ? 0 : c - step_n;
            if (c > d) ramp_per[i] = period_for(c);
            else ramp_fin[i] = 1'b0;
          end
          cur_pw[i]   = c & ((1 << DutyW) - 1);
          duty_now[i] = cur_pw[i];
          pwm_en      = 1'b1;
        end
        // on the way down the flag is cleared as each channel reaches zero
        if (powered ? !ramp_fin[i] : ramp_fin[i]) all_fin = 1'b0;
      end
      if (all_fin) begin
        timer_on = 1'b0;
        if (!powered) begin
          pwm_en = 1'b0;
          for (i = 0; i < 3; i++) duty_now[i] = 0;
        end
      end
    end
    o.duty_ch1      = DutyW'(pwm_en ? duty_now[0] : 0);
    o.duty_ch2      = DutyW'(pwm_en ? duty_now[1] : 0);
    o.duty_ch3      = DutyW'(pwm_en ? duty_now[2] : 0);
    o.period_ch1    = PeriodW'(ramp_per[0]);
    o.period_ch2    = PeriodW'(ramp_per[1]);
    o.period_ch3    = PeriodW'(ramp_per[2]);
    o.ramp_timer_on = timer_on;
    o.pwm_on        = pwm_en;
    o.window_active = powered;
    return o;
  endfunction

  function automatic sld_in_t clock_req(int unsigned sec);
    sld_in_t r;
    r.func         = FuncTime;
    r.time_hour    = HourW'(sec / 3600);
    r.time_minute  = MinuteW'((sec % 3600) / 60);
    r.time_second  = SecW'(sec % 60);
    r.expired_mask = '0;
    return r;
  endfunction

  function automatic sld_in_t expiry_req(logic [MaskW-1:0] mask);
    return '{FuncExpiry, HourW'(0), MinuteW'(0), SecW'(0), mask};
  endfunction

  function automatic script_row_t ask(sld_in_t r, logic pinned = 1'b0,
                                      sld_out_t want = '0);
    script_row_t row;
    row        = '0;
    row.kind   = ROW_REQUEST;
    row.req    = r;
    row.pinned = pinned;
    row.want   = want;
    return row;
  endfunction

  function automatic script_row_t setup(dimmer_cfg_t c);
    script_row_t row;
    row      = '0;
    row.kind = ROW_SETTINGS;
    row.cfg  = c;
    return row;
  endfunction

  function automatic int unsigned pick_level(int unsigned lo, int unsigned hi,
                                             int unsigned mid_hi);
    case ($urandom_range(0, 7))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(lo, mid_hi);
    endcase
  endfunction

  task automatic send_request(sld_in_t r, logic pinned, sld_out_t want);
    int       gap;
    sld_out_t due;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.data  <= r;
    do @(posedge clk_i); while (!item_if.ready);
    due = step_dimmer(r);
    pending_levels.push_back(pinned ? want : due);
  endtask

  // registers are only touched once every request has been answered
  task automatic settle();
    item_if.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_settings(dimmer_cfg_t c);
    cfg_idx_e r;
    r = r.first();
    repeat (r.num()) begin
      cfg_we_i  <= 1'b1;
      cfg_idx_i <= r;
      case (r)
        CFG_TARGET_CH1: cfg_wdata_i <= CfgDataW'(c.target_ch1);
        CFG_TARGET_CH2: cfg_wdata_i <= CfgDataW'(c.target_ch2);
        CFG_TARGET_CH3: cfg_wdata_i <= CfgDataW'(c.target_ch3);
        CFG_WIN_START:  cfg_wdata_i <= CfgDataW'(c.win_start);
        CFG_WIN_STOP:   cfg_wdata_i <= CfgDataW'(c.win_stop);
        CFG_SMOOTH:     cfg_wdata_i <= CfgDataW'(c.smooth);
        CFG_DIVISOR:    cfg_wdata_i <= CfgDataW'(c.divisor);
        CFG_RAMP_STEP:  cfg_wdata_i <= CfgDataW'(c.step);
        default:        cfg_wdata_i <= '0;
      endcase
      @(posedge clk_i);
      r = r.next();
    end
    cfg_we_i    <= 1'b0;
    tgt_duty[0] = c.target_ch1;
    tgt_duty[1] = c.target_ch2;
    tgt_duty[2] = c.target_ch3;
    win_lo      = c.win_start;
    win_hi      = c.win_stop;
    smooth_on   = c.smooth;
    div_n       = c.divisor;
    step_n      = c.step;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endtask

  initial begin
    sld_out_t  want;
    int        stall;
    result_if.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (!result_if.valid);
      if (pending_levels.size() == 0) begin
        $error("result with no request pending");
        fault_count++;
      end else begin
        want = pending_levels.pop_front();
        check_field("duty_ch1", want.duty_ch1, result_if.data.duty_ch1);
        check_field("duty_ch2", want.duty_ch2, result_if.data.duty_ch2);
        check_field("duty_ch3", want.duty_ch3, result_if.data.duty_ch3);
        check_field("period_ch1", want.period_ch1, result_if.data.period_ch1);
        check_field("period_ch2", want.period_ch2, result_if.data.period_ch2);
        check_field("period_ch3", want.period_ch3, result_if.data.period_ch3);
        check_field("ramp_timer_on", want.ramp_timer_on, result_if.data.ramp_timer_on);
        check_field("pwm_on", want.pwm_on, result_if.data.pwm_on);
        check_field("window_active", want.window_active, result_if.data.window_active);
      end
    end
  end

  initial begin
    dimmer_cfg_t c;
    sld_in_t     req;
    int unsigned lo, hi, made, burst;
    int          i;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_TARGET_CH1;
    cfg_wdata_i   <= '0;
    item_if.valid <= 1'b0;
    item_if.data  <= '0;
    fault_count = 0;
    no_idle     = 1'b0;
    for (i = 0; i < 3; i++) begin
      tgt_duty[i] = 0;
      cur_pw[i]   = 0;
      dest_pw[i]  = 0;
      ramp_per[i] = StartPeriod;
      duty_now[i] = 0;
      ramp_fin[i] = 1'b0;
    end
    win_lo    = 0;
    win_hi    = 0;
    smooth_on = 1'b0;
    div_n     = DivisorReset;
    step_n    = StepReset;
    powered   = 1'b0;
    timer_on  = 1'b0;
    pwm_en    = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset state: empty window, expiry ignored while the timer is stopped
    script.push_back(ask(clock_req(0), 1'b1, Dark));
    script.push_back(ask(expiry_req(3'b111), 1'b1, Dark));
    // instant switching
    script.push_back(setup('{10'd1000, 10'd0, 10'd500, 17'd3600, 17'd86399, 1'b0,
                             10'd10, 10'd10}));
    script.push_back(ask(clock_req(3599), 1'b1, Dark));
    script.push_back(ask(clock_req(3600), 1'b1, Lit));
    script.push_back(ask(expiry_req(3'b111), 1'b1, Lit));
    script.push_back(ask(clock_req(86399), 1'b1, Dark));
    // time fields beyond their range land past the end of the day
    script.push_back(ask('{FuncTime, 5'd31, 6'd63, 6'd63, 3'd0}, 1'b1, Dark));
    // soft ramp with the largest step and divisor
    script.push_back(setup('{10'd1000, 10'd1000, 10'd1, 17'd0, 17'd86399, 1'b1,
                             10'd1000, 10'd1000}));
    script.push_back(ask(clock_req(43200)));
    script.push_back(ask(expiry_req(3'b111)));
    script.push_back(ask(clock_req(86399)));
    script.push_back(ask(expiry_req(3'b001)));
    script.push_back(ask(expiry_req(3'b110)));
    script.push_back(ask(expiry_req(3'b111)));
    // unit step, zero divisor, switched off part way up
    script.push_back(setup('{10'd0, 10'd1000, 10'd999, 17'd21600, 17'd64800, 1'b1,
                             10'd0, 10'd1}));
    script.push_back(ask(clock_req(21600)));
    script.push_back(ask(expiry_req(3'b101)));
    script.push_back(ask(expiry_req(3'b010)));
    script.push_back(ask(expiry_req(3'b000)));
    script.push_back(ask(clock_req(64800)));
    script.push_back(ask(expiry_req(3'b111)));
    script.push_back(ask(expiry_req(3'b111)));
    // inverted window never switches on
    script.push_back(setup('{10'd1000, 10'd1000, 10'd1000, 17'd50000, 17'd100, 1'b1,
                             10'd1, 10'd500}));
    script.push_back(ask(clock_req(50000)));
    script.push_back(ask(expiry_req(3'b111)));
    script.push_back(ask('{FuncTime, 5'd16, 6'd32, 6'd33, 3'd0}));

    foreach (script[k]) begin
      if (script[k].kind == ROW_SETTINGS) begin
        settle();
        load_settings(script[k].cfg);
      end else begin
        send_request(script[k].req, script[k].pinned, script[k].want);
      end
    end

    repeat (23) begin
      settle();
      c.target_ch1 = DutyW'(pick_level(0, 1000, 1000));
      c.target_ch2 = DutyW'(pick_level(0, 1000, 1000));
      c.target_ch3 = DutyW'(pick_level(0, 1000, 1000));
      c.divisor    = DutyW'(pick_level(1, 1000, 1000));
      c.step       = DutyW'(pick_level(1, 1000, 300));
      c.smooth     = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: begin
          lo = $urandom_range(1, 86399);
          hi = $urandom_range(0, lo - 1);
        end
        1: begin
          lo = $urandom_range(0, 86399);
          hi = lo;
        end
        2: begin
          lo = 0;
          hi = 86399;
        end
        default: begin
          lo = $urandom_range(0, 86000);
          hi = $urandom_range(lo + 1, 86399);
        end
      endcase
      c.win_start = SecondW'(lo);
      c.win_stop  = SecondW'(hi);
      no_idle     = ($urandom_range(0, 4) == 0);
      load_settings(c);

      // mostly a time request followed by a run of expiries
      made = 0;
      while (made < 50) begin
        case ($urandom_range(0, 9))
          0, 1:    req = '{FuncTime, HourW'($urandom), MinuteW'($urandom),
                           SecW'($urandom), MaskW'(0)};
          2, 3, 4: req = clock_req($urandom_range(0, 86399));
          default: req = clock_req((lo < hi) ? $urandom_range(lo, hi - 1)
                                             : $urandom_range(0, 86399));
        endcase
        req.expired_mask = MaskW'($urandom);
        send_request(req, 1'b0, '0);
        made++;
        burst = $urandom_range(0, 6);
        repeat (burst) begin
          req = '{FuncExpiry, HourW'($urandom), MinuteW'($urandom), SecW'($urandom),
                  ($urandom_range(0, 2) != 0) ? 3'b111 : MaskW'($urandom)};
          send_request(req, 1'b0, '0);
          made++;
        end
      end
    end

    settle();
    repeat (60) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl/core
rtl/core/sld_pkg.sv
rtl/core/sld_in_if.sv
rtl/core/sld_out_if.sv
rtl/core/sld_ctrl.sv
rtl/core/sld_datapath.sv
rtl/core/scheduled_led_soft_ramp_dimmer_core.sv
rtl/core/sld_checker.sv
sim/testbench.sv
